// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled away when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/kts_pkg.sv =====
// ----------------------------------------------------------------------------
// kts_pkg
// Shared types and constants of the keyframe track sampler
// ----------------------------------------------------------------------------
package kts_pkg;

    localparam int MAX_KEYS_DEF = 64;
    localparam int VAL_W        = 16;
    localparam int TIME_W       = 16;
    localparam int FRAC_W       = 17;
    localparam int CFG_AW       = 4;

    localparam logic [1:0] REG_COMBINE_MODE = 2'd0;
    localparam logic [1:0] REG_KEY_COUNT    = 2'd1;
    localparam logic [1:0] REG_BIND_X       = 2'd2;
    localparam logic [1:0] REG_BIND_Y       = 2'd3;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREV,
        ST_DIV,
        ST_MUL_L,
        ST_ADD_L,
        ST_MUL_C,
        ST_FIN_C
    } kts_state_t;

    typedef struct packed {
        logic                     start;
        logic [TIME_W-1:0]        num;
        logic [TIME_W-1:0]        den;
    } kts_div_req_t;

    typedef struct packed {
        logic                     done;
        logic [FRAC_W-1:0]        quot;
    } kts_div_rsp_t;

endpackage

// ===== hw/rtl/keyframe_track_sampler.sv =====
// ----------------------------------------------------------------------------
// keyframe_track_sampler
// Keyframe table with linear interpolation and bind pose combine
// ----------------------------------------------------------------------------
// A write word stores one key in the table memory, which has one write port
// and one read port. A sample word scans the table from key 0 one entry per
// cycle (one read per cycle on the table memory) until the first key whose
// time is not below the sample time, or the last key. An end key then goes
// straight to the bind pose combine; an interpolated sample first reads the
// previous key and uses the 16-step divider for the fraction and the shared
// multiplier four times. The result waits in an output register; the
// next word is taken once the current sample has finished.
module keyframe_track_sampler #(
    parameter int MAX_KEYS = kts_pkg::MAX_KEYS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // config port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [kts_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // input words
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // key_slot[5:0], key_time[21:6], key_value_x[37:22], key_value_y[53:38],
    // sample_time[69:54], zero fill
    input  logic [71:0]                s_tdata,
    // req_type
    input  logic                       s_tuser,
    // results
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // pose_x[15:0], pose_y[31:16]
    output logic [31:0]                m_tdata
);
    import kts_pkg::*;

    localparam int AW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int EW  = TIME_W + 2 * VAL_W;

    // configuration registers
    logic                    mode_reg;
    logic [6:0]              kcount_reg;
    logic signed [VAL_W-1:0] bind_x_reg, bind_y_reg;
    logic                    cfg_we;

    // input fields
    logic [5:0]              in_slot;
    logic [TIME_W-1:0]       in_time, in_stime;
    logic [VAL_W-1:0]        in_x, in_y;
    logic                    s_fire;

    // table memory
    logic [EW-1:0]           mem [MAX_KEYS];
    logic [EW-1:0]           rdata_reg;
    logic [AW-1:0]           rd_addr;
    logic                    mem_we;
    logic [TIME_W-1:0]       r_time;
    logic signed [VAL_W-1:0] r_x, r_y;

    // control
    kts_state_t              state_reg, state_next;
    logic [AW-1:0]           cur_reg, cur_next;
    logic [AW-1:0]           last_reg, last_next;
    logic                    comp_reg, comp_next;
    logic [TIME_W-1:0]       stime_reg, stime_next;
    logic [TIME_W-1:0]       t1_reg, t1_next;
    logic signed [VAL_W-1:0] v1x_reg, v1x_next, v1y_reg, v1y_next;
    logic signed [VAL_W-1:0] v0x_reg, v0x_next, v0y_reg, v0y_next;
    logic signed [VAL_W-1:0] valx_reg, valx_next, valy_reg, valy_next;
    logic signed [VAL_W-1:0] resx_reg, resx_next;
    logic [FRAC_W-1:0]       frac_reg, frac_next;
    logic signed [34:0]      prod_reg, prod_next;
    logic                    out_v_reg, out_v_next;
    logic [31:0]             out_d_reg, out_d_next;

    kts_div_req_t            div_req;
    kts_div_rsp_t            div_rsp;

    // datapath helpers
    logic                    hit;
    logic signed [VAL_W:0]   ldiff;
    logic signed [VAL_W-1:0] lv0, cb, cv;
    logic signed [34:0]      lmul, cmul, mul_out;
    logic signed [34:0]      lround;
    logic signed [34:0]      cround;
    logic signed [VAL_W:0]   csum;
    logic signed [VAL_W-1:0] csat, lres;

    assign in_slot  = s_tdata[5:0];
    assign in_time  = s_tdata[21:6];
    assign in_x     = s_tdata[37:22];
    assign in_y     = s_tdata[53:38];
    assign in_stime = s_tdata[69:54];

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b0;
            kcount_reg <= 7'd1;
            bind_x_reg <= '0;
            bind_y_reg <= '0;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                REG_COMBINE_MODE: mode_reg   <= pwdata[0];
                REG_KEY_COUNT:    kcount_reg <= pwdata[6:0];
                REG_BIND_X:       bind_x_reg <= pwdata[15:0];
                REG_BIND_Y:       bind_y_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_COMBINE_MODE: prdata = {31'd0, mode_reg};
            REG_KEY_COUNT:    prdata = {25'd0, kcount_reg};
            REG_BIND_X:       prdata = {16'd0, bind_x_reg};
            REG_BIND_Y:       prdata = {16'd0, bind_y_reg};
            default:          prdata = '0;
        endcase
    end

    // ---------------- table memory ----------------
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign mem_we   = s_fire && (s_tuser == REQ_WRITE) && (32'(in_slot) < MAX_KEYS);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[AW'(in_slot)] <= {in_y, in_x, in_time};
        end
        rdata_reg <= mem[rd_addr];
    end

    assign r_time = rdata_reg[TIME_W-1:0];
    assign r_x    = rdata_reg[TIME_W +: VAL_W];
    assign r_y    = rdata_reg[TIME_W+VAL_W +: VAL_W];

    kts_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ---------------- shared arithmetic ----------------
    always_comb begin
        lv0    = comp_reg ? v0y_reg : v0x_reg;
        ldiff  = comp_reg ? ((VAL_W+1)'(v1y_reg) - (VAL_W+1)'(v0y_reg))
                          : ((VAL_W+1)'(v1x_reg) - (VAL_W+1)'(v0x_reg));
        cb     = comp_reg ? bind_y_reg : bind_x_reg;
        cv     = comp_reg ? valy_reg : valx_reg;
        lmul   = 35'(ldiff) * 35'(signed'({1'b0, frac_reg}));
        cmul   = 35'(cb) * 35'(cv);
        mul_out = (state_reg == ST_MUL_L) ? lmul : cmul;
        // round to nearest, ties up, then back to Q8.8
        lround = (prod_reg + 35'sd32768) >>> 16;
        lres   = VAL_W'(35'(lv0) + lround);
        cround = (prod_reg + 35'sd128) >>> 8;
        csum   = (VAL_W+1)'(cb) + (VAL_W+1)'(cv);
        if (mode_reg) begin
            if (cround > 35'sd32767) begin
                csat = 16'sh7fff;
            end else if (cround < -35'sd32768) begin
                csat = -16'sh8000;
            end else begin
                csat = VAL_W'(cround);
            end
        end else begin
            if (csum > 17'sd32767) begin
                csat = 16'sh7fff;
            end else if (csum < -17'sd32768) begin
                csat = -16'sh8000;
            end else begin
                csat = VAL_W'(csum);
            end
        end
    end

    assign hit = (r_time >= stime_reg);

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        cur_next   = cur_reg;
        last_next  = last_reg;
        comp_next  = comp_reg;
        stime_next = stime_reg;
        t1_next    = t1_reg;
        v1x_next   = v1x_reg;
        v1y_next   = v1y_reg;
        v0x_next   = v0x_reg;
        v0y_next   = v0y_reg;
        valx_next  = valx_reg;
        valy_next  = valy_reg;
        resx_next  = resx_reg;
        frac_next  = frac_reg;
        prod_next  = prod_reg;
        out_v_next = out_v_reg;
        out_d_next = out_d_reg;
        rd_addr    = cur_reg;
        div_req.start = 1'b0;
        div_req.num   = stime_reg - r_time;
        div_req.den   = t1_reg - r_time;

        if (out_v_reg && m_tready) begin
            out_v_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                rd_addr = '0;
                if (s_fire && (s_tuser == REQ_SAMPLE)) begin
                    cur_next   = '0;
                    stime_next = in_stime;
                    comp_next  = 1'b0;
                    if (kcount_reg == 7'd0) begin
                        last_next = '0;
                    end else if (32'(kcount_reg) > MAX_KEYS) begin
                        last_next = AW'(MAX_KEYS - 1);
                    end else begin
                        last_next = AW'(kcount_reg - 7'd1);
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit && (cur_reg != '0)) begin
                    t1_next    = r_time;
                    v1x_next   = r_x;
                    v1y_next   = r_y;
                    rd_addr    = cur_reg - AW'(1);
                    state_next = ST_PREV;
                end else if (hit || (cur_reg == last_reg)) begin
                    valx_next  = r_x;
                    valy_next  = r_y;
                    state_next = ST_MUL_C;
                end else begin
                    rd_addr    = cur_reg + AW'(1);
                    cur_next   = cur_reg + AW'(1);
                end
            end
            ST_PREV: begin
                v0x_next      = r_x;
                v0y_next      = r_y;
                div_req.start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    frac_next  = div_rsp.quot;
                    state_next = ST_MUL_L;
                end
            end
            ST_MUL_L: begin
                prod_next  = mul_out;
                state_next = ST_ADD_L;
            end
            ST_ADD_L: begin
                if (comp_reg) begin
                    valy_next  = lres;
                    comp_next  = 1'b0;
                    state_next = ST_MUL_C;
                end else begin
                    valx_next  = lres;
                    comp_next  = 1'b1;
                    state_next = ST_MUL_L;
                end
            end
            ST_MUL_C: begin
                prod_next  = mul_out;
                state_next = ST_FIN_C;
            end
            ST_FIN_C: begin
                if (!comp_reg) begin
                    resx_next  = csat;
                    comp_next  = 1'b1;
                    state_next = ST_MUL_C;
                end else if (!out_v_reg || m_tready) begin
                    out_v_next = 1'b1;
                    out_d_next = {csat, resx_reg};
                    comp_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_v_reg <= 1'b0;
            comp_reg  <= 1'b0;
            cur_reg   <= '0;
            last_reg  <= '0;
        end else begin
            state_reg <= state_next;
            out_v_reg <= out_v_next;
            comp_reg  <= comp_next;
            cur_reg   <= cur_next;
            last_reg  <= last_next;
        end
        stime_reg <= stime_next;
        t1_reg    <= t1_next;
        v1x_reg   <= v1x_next;
        v1y_reg   <= v1y_next;
        v0x_reg   <= v0x_next;
        v0y_reg   <= v0y_next;
        valx_reg  <= valx_next;
        valy_reg  <= valy_next;
        resx_reg  <= resx_next;
        frac_reg  <= frac_next;
        prod_reg  <= prod_next;
        out_d_reg <= out_d_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;

    // ---------------- checks ----------------
    `include "assert_macros.svh"

    `ASSERT_IMPLIES(a_div_done_in_div, aclk, aresetn, div_rsp.done, state_reg == ST_DIV, "divider finished outside the divide step")
    `ASSERT_IMPLIES(a_scan_in_range, aclk, aresetn, state_reg == ST_SCAN, cur_reg <= last_reg, "scan ran past the last key")
    `ASSERT_NEXT(a_sample_blocks, aclk, aresetn, s_fire && (s_tuser == REQ_SAMPLE), !s_tready, "new word taken during a sample")

endmodule

// ===== hw/rtl/kts_div.sv =====
// ----------------------------------------------------------------------------
// kts_div
// Radix-2 restoring divider giving floor(num * 65536 / den), num <= den
// ----------------------------------------------------------------------------
module kts_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  kts_pkg::kts_div_req_t req,
    output kts_pkg::kts_div_rsp_t rsp
);
    import kts_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [TIME_W-1:0]   rem_reg, rem_next;
    logic [TIME_W-1:0]   den_reg, den_next;
    logic [FRAC_W-1:0]   q_reg, q_next;
    logic [TIME_W:0]     rem_sh;
    logic [TIME_W:0]     rem_sub;

    always_comb begin
        rem_sh    = {rem_reg, 1'b0};
        rem_sub   = rem_sh - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        if (req.start) begin
            den_next = req.den;
            if (req.num == req.den) begin
                // fraction of exactly one
                q_next    = {1'b1, {TIME_W{1'b0}}};
                done_next = 1'b1;
            end else begin
                rem_next  = req.num;
                q_next    = '0;
                cnt_next  = 5'd16;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, den_reg}) begin
                rem_next = rem_sub[TIME_W-1:0];
                q_next   = {q_reg[FRAC_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[TIME_W-1:0];
                q_next   = {q_reg[FRAC_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyframe track sampler: writes keys, samples
// the track under random bursts and stalls, and checks every pose result
// ----------------------------------------------------------------------------
class pose_scoreboard;
    logic [15:0] key_time_mem [64];
    logic signed [15:0] key_x_mem [64];
    logic signed [15:0] key_y_mem [64];
    logic        mode;
    logic [6:0]  count;
    logic signed [15:0] bind_x;
    logic signed [15:0] bind_y;
    logic [31:0] pose_queue [$];
    int errors;
    int checked;

    function void clear();
        mode = 1'b0;
        count = 7'd1;
        bind_x = '0;
        bind_y = '0;
        errors = 0;
        checked = 0;
        foreach (key_time_mem[i]) begin
            key_time_mem[i] = '0;
            key_x_mem[i] = '0;
            key_y_mem[i] = '0;
        end
    endfunction

    function logic signed [15:0] sat16(longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    function longint lerp(longint v0, longint v1, longint a);
        longint p;
        p = (v1 - v0) * a + 32768;
        return v0 + (p >>> 16);
    endfunction

    function logic signed [15:0] combine(longint b, longint v);
        if (mode == 1'b0) return sat16(b + v);
        return sat16((b * v + 128) >>> 8);
    endfunction

    // note an accepted input word
    function void note_word(logic kind, logic [71:0] d);
        int n;
        int i;
        longint s;
        longint vx;
        longint vy;
        longint dd;
        longint ff;
        longint a;
        if (kind == kts_pkg::REQ_WRITE) begin
            key_time_mem[d[5:0]] = d[21:6];
            key_x_mem[d[5:0]] = d[37:22];
            key_y_mem[d[5:0]] = d[53:38];
            return;
        end
        n = count;
        if (n == 0) n = 1;
        if (n > 64) n = 64;
        s = d[69:54];
        for (i = 0; i < n; i++)
            if (key_time_mem[i] >= s) break;
        if (i == n || i == 0) begin
            i = (i == n) ? n - 1 : 0;
            vx = key_x_mem[i];
            vy = key_y_mem[i];
        end else begin
            dd = s - key_time_mem[i-1];
            ff = longint'(key_time_mem[i]) - key_time_mem[i-1];
            a = (dd << 16) / ff;
            vx = lerp(key_x_mem[i-1], key_x_mem[i], a);
            vy = lerp(key_y_mem[i-1], key_y_mem[i], a);
        end
        pose_queue.push_back({combine(bind_y, vy), combine(bind_x, vx)});
    endfunction

    function void check_pose(logic [31:0] got);
        logic [31:0] want;
        if (pose_queue.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected pose %h", got);
            return;
        end
        want = pose_queue.pop_front();
        checked++;
        if (want[15:0] !== got[15:0] || want[31:16] !== got[31:16]) begin
            errors++;
            if (errors <= 10)
                $display("pose mismatch: x exp %h got %h, y exp %h got %h",
                         want[15:0], got[15:0], want[31:16], got[31:16]);
        end
    endfunction
endclass

module tb;
    import kts_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    pose_scoreboard board;
    int  hold_cycles;
    bit  stall_on;
    int  samples_sent;
    int  writes_sent;
    int  settings_used;
    logic [15:0] sorted_times [64];

    keyframe_track_sampler DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("status: fail");
        $finish;
    end

    // receiver: random stall pattern, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) board.check_pose(m_tdata);
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 1'b0;
            end else if (stall_on) begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_COMBINE_MODE: board.mode = val[0];
            REG_KEY_COUNT:    board.count = val[6:0];
            REG_BIND_X:       board.bind_x = val[15:0];
            default:          board.bind_y = val[15:0];
        endcase
    endtask

    // offer one word; the valid stays high into the next send when no gap
    task automatic send_word(logic kind, logic [71:0] d, bit gap);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        board.note_word(kind, d);
        if (kind == REQ_SAMPLE) samples_sent++;
        else writes_sent++;
        if (gap) begin
            s_tvalid <= 1'b0;
            s_tdata <= {$urandom, $urandom, $urandom};
            s_tuser <= $urandom_range(0, 1);
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    function automatic logic [71:0] key_word(int slot, logic [15:0] t,
                                             logic [15:0] x, logic [15:0] y);
        logic [15:0] junk;
        junk = $urandom;
        return {2'b00, junk, y, x, t, slot[5:0]};
    endfunction

    function automatic logic [71:0] sample_word(logic [15:0] s);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        return {2'b00, s, junk[53:0]};
    endfunction

    function automatic logic [15:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return $urandom_range(0, 1023) - 512;
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pose_queue.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    // write all 64 keys in non-decreasing time order with random spacing
    task automatic fill_table(int spread, bit gappy);
        int t;
        t = $urandom_range(0, spread);
        for (int k = 0; k < 64; k++) begin
            sorted_times[k] = (t > 65535) ? 16'hffff : t[15:0];
            send_word(REQ_WRITE, key_word(k, sorted_times[k], rand_val(), rand_val()),
                      gappy && ($urandom_range(0, 3) == 0));
            t += $urandom_range(0, spread);
        end
    endtask

    function automatic logic [15:0] rand_sample(int n);
        int k;
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return sorted_times[k];
            3: return sorted_times[k] + 1;
            default: return $urandom_range(0, sorted_times[n-1] + 20);
        endcase
    endfunction

    task automatic random_phase(int items, logic mode, int n,
                                logic [15:0] bx, logic [15:0] by, int hold);
        int burst;
        wait_drained();
        reg_write(REG_COMBINE_MODE, {$urandom} & ~32'h1 | mode);
        reg_write(REG_KEY_COUNT, n);
        reg_write(REG_BIND_X, bx);
        reg_write(REG_BIND_Y, by);
        settings_used++;
        hold_cycles = hold;
        burst = 0;
        for (int j = 0; j < items; j++) begin
            if (burst == 0) burst = $urandom_range(1, 12);
            burst--;
            if ($urandom_range(0, 9) == 0) begin
                // rewrite a key in place, within the times of its neighbors
                int k;
                k = $urandom_range(0, 63);
                send_word(REQ_WRITE, key_word(k, sorted_times[k], rand_val(), rand_val()),
                          burst == 0);
            end else begin
                send_word(REQ_SAMPLE, sample_word(rand_sample(n < 1 ? 1 : (n > 64 ? 64 : n))),
                          burst == 0);
            end
        end
    endtask

    initial begin
        board = new();
        board.clear();
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        hold_cycles = 0;
        stall_on = 1'b0;
        samples_sent = 0;
        writes_sent = 0;
        settings_used = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extreme keys, reset config, key count one
        send_word(REQ_WRITE, key_word(0, 16'd100, 16'h7fff, 16'h8000), 1'b0);
        send_word(REQ_WRITE, key_word(1, 16'd200, 16'h8000, 16'h7fff), 1'b0);
        send_word(REQ_WRITE, key_word(63, 16'hffff, 16'h0100, 16'hff00), 1'b1);
        send_word(REQ_SAMPLE, sample_word(16'd0), 1'b0);
        send_word(REQ_SAMPLE, sample_word(16'hffff), 1'b1);
        wait_drained();
        reg_write(REG_KEY_COUNT, 32'd2);
        send_word(REQ_SAMPLE, sample_word(16'd100), 1'b0);
        send_word(REQ_SAMPLE, sample_word(16'd101), 1'b0);
        send_word(REQ_SAMPLE, sample_word(16'd150), 1'b0);
        send_word(REQ_SAMPLE, sample_word(16'd199), 1'b0);
        send_word(REQ_SAMPLE, sample_word(16'd200), 1'b0);
        send_word(REQ_SAMPLE, sample_word(16'd201), 1'b1);
        wait_drained();
        reg_write(REG_BIND_X, 32'h7fff);
        reg_write(REG_BIND_Y, 32'h8000);
        send_word(REQ_SAMPLE, sample_word(16'd150), 1'b0);
        send_word(REQ_SAMPLE, sample_word(16'd0), 1'b1);
        wait_drained();
        reg_write(REG_COMBINE_MODE, 32'd1);
        send_word(REQ_SAMPLE, sample_word(16'd150), 1'b0);
        send_word(REQ_SAMPLE, sample_word(16'd200), 1'b1);

        // full table, key count zero and above the table size
        fill_table(1000, 1'b1);
        random_phase(10, 1'b0, 0, 16'h0000, 16'h0000, 0);
        random_phase(10, 1'b1, 127, 16'h0100, 16'hff00, 0);

        stall_on = 1'b1;
        random_phase(100, 1'b0, 64, $urandom, $urandom, 0);

        // receiver holds off while the sender keeps offering
        random_phase(100, 1'b1, $urandom_range(2, 64), $urandom, $urandom, 600);
        fill_table(4, 1'b0);
        random_phase(100, 1'b0, $urandom_range(1, 64), 16'h8000, 16'h7fff, 0);
        fill_table(3000, 1'b1);
        stall_on = 1'b0;
        random_phase(100, 1'b1, 64, 16'h7fff, 16'h8000, 0);

        s_tvalid <= 1'b0;
        wait_drained();
        $display("covered %0d samples, %0d key writes, %0d register settings",
                 samples_sent, writes_sent, settings_used);
        $display("checked %0d poses, %0d mismatches", board.checked, board.errors);
        if (board.errors == 0 && board.pose_queue.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
